[rtl/kwsm_pkg.sv]
package kwsm_pkg;

   // configuration port geometry
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 64;
   localparam int KEY_LEN_W  = 5;
   localparam int KEY_BITS   = 128;

   // register index, taken from paddr[4:3]
   typedef enum logic [1:0] {
      REG_KEY_LENGTH = 2'd0,
      REG_KEY_LOW    = 2'd1,
      REG_KEY_HIGH   = 2'd2,
      REG_FOLD_CASE  = 2'd3
   } reg_index_type;

   // control shared by every cell of the window chain
   typedef struct packed {
      logic shift;
      logic clear;
      logic fold;
   } cell_ctrl_type;

endpackage

[rtl/kwsm_cell.sv]
module kwsm_cell
   import kwsm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cell_ctrl_type ctrl,
   input  logic          in_use,
   input  logic [7:0]    key_byte,
   input  logic [7:0]    prev_byte,
   input  logic          prev_filled,
   output logic [7:0]    cur_byte,
   output logic          cur_filled,
   output logic          ok
);

   logic [7:0] byte_ff;
   logic [7:0] byte_in;
   logic       filled_ff;
   logic       filled_in;
   logic       eq;

   // ascii upper case to lower case when folding is on
   function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic en);
      logic [7:0] r;
      r = b;
      if (en && (b >= 8'h41) && (b <= 8'h5A)) begin
         r = b + 8'h20;
      end
      return r;
   endfunction

   // compare against the byte that enters this cell on the current beat
   assign eq = (fold_byte(prev_byte, ctrl.fold) == fold_byte(key_byte, ctrl.fold));
   assign ok = !in_use || (prev_filled && eq);

   // shift the window by one position per accepted beat
   always_comb begin
      byte_in   = byte_ff;
      filled_in = filled_ff;
      if (ctrl.shift) begin
         byte_in   = prev_byte;
         filled_in = ctrl.clear ? 1'b0 : prev_filled;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         filled_ff <= 1'b0;
      end else begin
         filled_ff <= filled_in;
      end
   end

   assign cur_byte   = byte_ff;
   assign cur_filled = filled_ff;

endmodule

[rtl/keyword_substring_matcher_top.sv]
// Keyword substring matcher.
// The req channel carries one text byte per beat together with a last flag
// marking the final byte of a text. When a last beat is taken, one beat
// appears on the rsp channel telling whether the configured keyword occurred
// anywhere in that text; beats without last produce nothing.
// The keyword (up to KEY_MAX bytes), its length and a case fold bit are set
// through the csr port; the user must write them only while no text is in
// flight, and the block does not enforce this. Length 0 never matches.
// A chain of KEY_MAX cells holds the most recent text bytes; each cell
// compares its incoming byte against its keyword byte, and all cells settle
// in the cycle the byte is taken. Throughput is one byte per cycle while req
// is not stalled. The result of a last beat shows on rsp the cycle after it
// is taken. A pending result that the receiver stalls holds rsp and stalls
// req only while it waits.
// Reset clears the window, the found flag, the output valid flag and all
// configuration registers; the block can take input once reset is released.
module keyword_substring_matcher_top
   import kwsm_pkg::*;
#(
   parameter int KEY_MAX = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_text_byte,
   input  logic                  req_last,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_found,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int LEN_W     = $clog2(KEY_MAX + 1);
   localparam int KEY_IDX_W = $clog2(KEY_MAX);

   logic [KEY_LEN_W-1:0]  key_length_ff;
   logic [CSR_DATA_W-1:0] key_low_ff;
   logic [CSR_DATA_W-1:0] key_high_ff;
   logic                  fold_ff;
   logic [KEY_BITS-1:0]   key_all;
   logic [LEN_W-1:0]      len_eff;
   reg_index_type         csr_index;
   logic                  csr_write;

   logic                  accept;
   logic                  hit;
   logic                  match_seen_ff;
   logic                  match_seen_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic                  rsp_found_ff;
   logic                  rsp_found_in;
   cell_ctrl_type         ctrl;

   logic [7:0]            byte_chain [KEY_MAX+1];
   logic [KEY_MAX:0]      filled_chain;
   logic [KEY_MAX-1:0]    cell_ok;
   logic [KEY_MAX-1:0]    cell_in_use;

   // csr write and read
   assign csr_pready = 1'b1;
   assign csr_index  = reg_index_type'(csr_paddr[4:3]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_length_ff <= '0;
         key_low_ff    <= '0;
         key_high_ff   <= '0;
         fold_ff       <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_KEY_LENGTH: key_length_ff <= csr_pwdata[KEY_LEN_W-1:0];
            REG_KEY_LOW:    key_low_ff    <= csr_pwdata;
            REG_KEY_HIGH:   key_high_ff   <= csr_pwdata;
            REG_FOLD_CASE:  fold_ff       <= csr_pwdata[0];
            default:        ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_KEY_LENGTH: csr_prdata = {{(CSR_DATA_W-KEY_LEN_W){1'b0}}, key_length_ff};
         REG_KEY_LOW:    csr_prdata = key_low_ff;
         REG_KEY_HIGH:   csr_prdata = key_high_ff;
         REG_FOLD_CASE:  csr_prdata = {{(CSR_DATA_W-1){1'b0}}, fold_ff};
         default:        csr_prdata = '0;
      endcase
   end

   // length in use, saturated at the window size
   assign key_all = {key_high_ff, key_low_ff};
   assign len_eff = (key_length_ff > KEY_LEN_W'(KEY_MAX)) ? LEN_W'(KEY_MAX)
                                                          : key_length_ff[LEN_W-1:0];

   // handshake
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   assign ctrl.shift = accept;
   assign ctrl.clear = accept && req_last;
   assign ctrl.fold  = fold_ff;

   // window chain, cell 0 takes the newest byte
   assign byte_chain[0]   = req_text_byte;
   assign filled_chain[0] = 1'b1;

   for (genvar j = 0; j < KEY_MAX; j++) begin : g_cell
      logic [LEN_W-1:0]     key_pos;
      logic [KEY_IDX_W-1:0] key_sel;

      // cell j lines up with keyword byte len-1-j
      assign cell_in_use[j] = (LEN_W'(j) < len_eff);
      assign key_pos        = len_eff - LEN_W'(j + 1);
      assign key_sel        = key_pos[KEY_IDX_W-1:0];

      kwsm_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .in_use      (cell_in_use[j]),
         .key_byte    (key_all[8*key_sel +: 8]),
         .prev_byte   (byte_chain[j]),
         .prev_filled (filled_chain[j]),
         .cur_byte    (byte_chain[j+1]),
         .cur_filled  (filled_chain[j+1]),
         .ok          (cell_ok[j])
      );
   end

   assign hit = (len_eff != '0) && (&cell_ok);

   // sticky found flag, cleared by the last beat
   always_comb begin
      match_seen_in = match_seen_ff;
      if (accept) begin
         match_seen_in = req_last ? 1'b0 : (match_seen_ff || hit);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_seen_ff <= 1'b0;
      end else begin
         match_seen_ff <= match_seen_in;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_found_in = rsp_found_ff;
      if (accept && req_last) begin
         rsp_valid_in = 1'b1;
         rsp_found_in = match_seen_ff || hit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_found_ff <= rsp_found_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_found = rsp_found_ff;

   // checks
   a_last_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      accept && req_last |=> rsp_valid_ff)
      else $error("last beat did not load the result register");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_last |=> !match_seen_ff && (filled_chain[KEY_MAX:1] == '0))
      else $error("state not cleared after last beat");

   a_fill_thermo: assert property (@(posedge clock) disable iff (reset)
      (filled_chain[KEY_MAX:1] & (filled_chain[KEY_MAX:1] + 1'b1)) == '0)
      else $error("window fill bits not contiguous from the newest cell");

   a_zero_len_no_hit: assert property (@(posedge clock) disable iff (reset)
      (len_eff == '0) |-> !hit)
      else $error("hit with zero key length");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid_ff)
      else $error("input stalled with empty result register");

endmodule
